@@ rtl/core/bsb_pkg.sv @@
// Package for the B-spline basis evaluator: sizes, codes and state types.
// Used by the RAM-based core modules; depends on nothing.
`default_nettype none
package bsb_pkg;
  localparam int MaxOrderDef = 8;
  localparam int MaxKnotsDef = 64;
  localparam int KnotW = 32;
  localparam int BasisW = 31;
  localparam logic [BasisW-1:0] QOne = 31'h4000_0000;
  localparam logic OpWrite = 1'b0;
  localparam logic OpEval = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_INIT_RD, ST_INIT_CMP, ST_TERM_RD0, ST_TERM_RD1, ST_TERM_RD2,
    ST_TERM_RD3, ST_MUL, ST_DIV, ST_ACC, ST_OUT
  } state_t;
endpackage
`default_nettype wire

@@ rtl/core/bsb_ram.sv @@
// Generic single-port-write, one-read RAM with a registered read port.
// Stand-alone; used for the knot table and the working basis row.
`default_nettype none
module bsb_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ rtl/core/bsb_div.sv @@
// Serial restoring divider, signed 66-bit dividend by 34-bit divisor.
// Truncates toward zero and saturates the quotient to +/- 2^32.
`default_nettype none
module bsb_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [65:0] dividend,
  input  wire logic signed [33:0] divisor,
  output logic                    done,
  output logic signed [33:0]      quotient
);
  logic [65:0] quo;
  logic [34:0] rem;
  logic [33:0] dvs;
  logic        neg;
  logic [6:0]  cnt;
  logic        busy;
  logic [34:0] trial;
  logic [65:0] qmag;

  assign trial = {rem[33:0], quo[65]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 7'd66;
        rem  <= '0;
        quo  <= dividend[65] ? 66'(-dividend) : dividend;
        dvs  <= divisor[33] ? 34'(-divisor) : divisor;
        neg  <= dividend[65] ^ divisor[33];
      end else if (busy) begin
        if (!trial[34]) begin
          rem <= trial;
          quo <= {quo[64:0], 1'b1};
        end else begin
          rem <= {rem[33:0], quo[65]};
          quo <= {quo[64:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    qmag = (quo > 66'h1_0000_0000) ? 66'h1_0000_0000 : quo;
    quotient = neg ? 34'(-qmag[33:0]) : qmag[33:0];
  end
endmodule
`default_nettype wire

@@ rtl/core/bspline_basis_eval.sv @@
// Top level of the B-spline basis evaluator (Cox-de Boor triangle).
// Depends on bsb_pkg, bsb_ram and bsb_div.
//
//   channel | signals                                        | direction
//   input   | in_valid, in_stall, operation..param_mu        | transfer in
//   output  | out_valid, out_stall, basis_value, range_error | transfer out
//   config  | cfg_we, cfg_data                               | register write
//
// A knot write is stored straight from the idle state. An evaluation of order k
// first fills the order-one row, then works k(k-1)/2 terms of two divisions on
// the serial divider; a division whose denominator is zero is skipped.
// Reset clears control state and sets the order to four; knots stay unknown.
// A finished result waits in the output register while out_stall is high.
`default_nettype none
module bspline_basis_eval #(
  parameter int MaxOrder = bsb_pkg::MaxOrderDef,
  parameter int MaxKnots = bsb_pkg::MaxKnotsDef
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [3:0]            cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  operation,
  input  wire logic [5:0]            knot_index,
  input  wire logic signed [31:0]    knot_value,
  input  wire logic [5:0]            interval,
  input  wire logic signed [31:0]    param_mu,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [bsb_pkg::BasisW-1:0] basis_value,
  output logic                       range_error
);
  import bsb_pkg::*;

  localparam int KA = $clog2(MaxKnots);
  localparam int RA = (MaxOrder > 1) ? $clog2(MaxOrder + 1) : 1;
  localparam int OW = $clog2(MaxOrder + 1);

  state_t state, state_next;
  logic [3:0] spline_order;
  logic [OW-1:0] k_eff;
  logic [6:0] ivl;
  logic signed [32:0] mu;
  logic [OW-1:0] j, r;
  logic half;
  logic signed [32:0] tj, tj1, tjr1, tjr;
  logic [BasisW-1:0] bj, bj1;
  logic signed [34:0] acc;
  logic signed [65:0] prod;
  logic signed [33:0] den;
  logic div_start, div_done;
  logic signed [33:0] quot;

  logic kwe;
  logic [KA-1:0] kwa, kra;
  logic [31:0] kwd, krd;
  logic rwe;
  logic [RA-1:0] rwa, rra;
  logic [BasisW-1:0] rwd, rrd;

  // Effective order: zero counts as one, large values saturate.
  always_comb begin
    if (spline_order == 4'd0) k_eff = OW'(1);
    else if (32'(spline_order) > 32'(MaxOrder)) k_eff = OW'(MaxOrder);
    else k_eff = OW'(spline_order);
  end

  bsb_ram #(.Width(32), .Depth(MaxKnots)) u_knots (
    .clk, .we(kwe), .waddr(kwa), .wdata(kwd), .raddr(kra), .rdata(krd)
  );
  bsb_ram #(.Width(BasisW), .Depth(MaxOrder + 1)) u_row (
    .clk, .we(rwe), .waddr(rwa), .wdata(rwd), .raddr(rra), .rdata(rrd)
  );
  bsb_div u_div (
    .clk, .rst, .start(div_start), .dividend(prod), .divisor(den),
    .done(div_done), .quotient(quot)
  );

  logic [6:0] p;
  assign p = ivl + 7'(j);

  // Knot read address per state.
  always_comb begin
    case (state)
      ST_INIT_RD:  kra = KA'(p);
      ST_INIT_CMP: kra = KA'(p + 7'd1);
      ST_TERM_RD0: kra = KA'(p);
      ST_TERM_RD1: kra = KA'(p + 7'd1);
      ST_TERM_RD2: kra = KA'(p + 7'(r) - 7'd1);
      ST_TERM_RD3: kra = KA'(p + 7'(r));
      default:     kra = KA'(p);
    endcase
  end

  assign kwe = (state == ST_IDLE) && in_valid && !out_valid &&
               (operation == OpWrite) && (32'(knot_index) < 32'(MaxKnots));
  assign kwa = KA'(knot_index);
  assign kwd = knot_value;
  assign in_stall = (state != ST_IDLE) || out_valid;

  logic signed [32:0] kv;
  assign kv = {krd[31], krd};

  // Order-one value of the current span: one when knot[p] <= mu < knot[p+1].
  logic [BasisW-1:0] ord1_val;
  assign ord1_val = (tj <= mu && mu < kv) ? QOne : '0;

  // Term operands: first or second half of the sum.
  always_comb begin
    if (!half) begin
      prod = (mu - tj) * $signed({1'b0, bj});
      den  = 34'(tjr1) - 34'(tj);
    end else begin
      prod = (tjr - mu) * $signed({1'b0, bj1});
      den  = 34'(tjr) - 34'(tj1);
    end
  end

  // A term whose denominator is zero adds nothing to the sum.
  logic signed [34:0] sum;
  logic [BasisW-1:0] sclamp;
  assign sum = acc + ((den == 34'sd0) ? 35'sd0 : 35'(quot));
  always_comb begin
    if (sum < 0) sclamp = '0;
    else if (sum > 35'(QOne)) sclamp = QOne;
    else sclamp = sum[BasisW-1:0];
  end

  always_comb begin
    state_next = state;
    div_start = 1'b0;
    rwe = 1'b0;
    rwa = RA'(j);
    rwd = sclamp;
    rra = RA'(j);
    case (state)
      ST_IDLE: begin
        if (in_valid && !out_valid && operation == OpEval) begin
          if (32'(interval) + 32'(k_eff) > 32'(MaxKnots - 1)) state_next = ST_OUT;
          else state_next = ST_INIT_RD;
        end
      end
      ST_INIT_RD: state_next = ST_INIT_CMP;
      ST_INIT_CMP: begin
        // krd holds knot[p] at this point
        state_next = ST_TERM_RD0;
      end
      ST_TERM_RD0: begin
        if (r == OW'(0)) begin
          // order-one compare: tj latched, krd now knot[p+1]
          rwe = 1'b1;
          rwd = ord1_val;
          if (j + OW'(1) != k_eff) state_next = ST_INIT_RD;
          else if (k_eff == OW'(1)) state_next = ST_OUT;
          else state_next = ST_TERM_RD0;
        end else state_next = ST_TERM_RD1;
      end
      ST_TERM_RD1: begin
        rra = RA'(j + OW'(1));
        state_next = ST_TERM_RD2;
      end
      ST_TERM_RD2: state_next = ST_TERM_RD3;
      ST_TERM_RD3: state_next = ST_MUL;
      ST_MUL: begin
        if (den != 34'sd0) begin
          div_start = 1'b1;
          state_next = ST_DIV;
        end else state_next = ST_ACC;
      end
      ST_DIV: if (div_done) state_next = ST_ACC;
      ST_ACC: begin
        if (!half) state_next = ST_MUL;
        else begin
          rwe = 1'b1;
          if (32'(j) + 32'(r) + 1 <= 32'(k_eff)) state_next = ST_TERM_RD0;
          else if (r == k_eff) state_next = ST_OUT;
          else state_next = ST_TERM_RD0;
        end
      end
      ST_OUT: if (!out_valid) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      spline_order <= 4'd4;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) spline_order <= cfg_data;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          // Only an accepted evaluation touches the result register, so a
          // result still waiting on out_stall stays intact.
          if (in_valid && !out_valid && operation == OpEval) begin
            ivl <= 7'(interval);
            mu <= 33'(param_mu);
            j <= '0;
            r <= '0;
            half <= 1'b0;
            acc <= '0;
            range_error <= 1'b1;
            basis_value <= '0;
          end
        end
        ST_INIT_CMP: tj <= kv;
        ST_TERM_RD0: begin
          if (r == OW'(0)) begin
            if (j + OW'(1) == k_eff) begin
              j <= '0;
              r <= OW'(2);
              if (k_eff == OW'(1)) begin
                basis_value <= ord1_val;
                range_error <= 1'b0;
              end
            end else j <= j + OW'(1);
          end
        end
        ST_TERM_RD1: begin
          tj <= kv;
          bj <= rrd;
        end
        ST_TERM_RD2: begin
          tj1 <= kv;
          bj1 <= rrd;
        end
        ST_TERM_RD3: tjr1 <= kv;
        ST_MUL: begin
          if (half == 1'b0 && acc == '0) tjr <= kv;
          if (den == 34'sd0) acc <= acc;
        end
        ST_ACC: begin
          if (!half) begin
            if (!(den == 34'sd0)) acc <= sum;
            half <= 1'b1;
          end else begin
            half <= 1'b0;
            acc <= '0;
            if (r == k_eff && j == '0) begin
              basis_value <= sclamp;
              range_error <= 1'b0;
            end else if (32'(j) + 32'(r) + 1 <= 32'(k_eff)) j <= j + OW'(1);
            else begin
              j <= '0;
              r <= r + OW'(1);
            end
          end
        end
        ST_OUT: if (!out_valid) out_valid <= 1'b1;
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/bsb_checker.sv @@
// Port-level checker for the B-spline basis evaluator, bound to the top.
// Depends on bsb_pkg for the result width.
`default_nettype none
module bsb_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       in_valid,
  input wire logic                       in_stall,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire logic [bsb_pkg::BasisW-1:0] basis_value,
  input wire logic                       range_error
);
  import bsb_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(basis_value))
    else $error("stalled result changed");
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && range_error |-> basis_value == '0)
    else $error("range error with nonzero value");
  a_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> basis_value <= QOne)
    else $error("basis value above one");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while result pending");
endmodule

bind bspline_basis_eval bsb_checker u_bsb_checker (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall,
  .basis_value, .range_error
);
`default_nettype wire

@@ test/bspline_basis_eval_tb.sv @@
// Testbench for bspline_basis_eval: directed table plus random knot/evaluate traffic,
// checked by typed rows or an in-bench Cox-de Boor predictor. Depends on bsb_pkg.
`timescale 1ns / 1ps
module bspline_basis_eval_tb;
  import bsb_pkg::*;

  localparam int TableDepth = 64;
  localparam int OrderCap = 8;
  localparam longint QUnit = 64'sd1 << 30;
  localparam longint TermCap = 64'sd1 << 32;
  localparam int CycleLimit = 20_000_000;
  localparam int NumPhases = 8;
  localparam int ItemsPerPhase = 44;

  // Result of one evaluation as the block should present it.
  typedef struct packed {
    logic [BasisW-1:0] basis;
    logic              err;
  } basis_result_t;

  // One row of the directed stimulus. Rows with typed set carry a hand-written
  // expectation; the others are checked against the predictor.
  typedef struct packed {
    logic        op;
    logic [5:0]  kidx;
    logic [31:0] kval;
    logic [5:0]  ivl;
    logic [31:0] mu;
    logic        typed;
    logic [30:0] exp_basis;
    logic        exp_err;
  } stim_row_t;

  localparam int NumDirected = 23;
  localparam stim_row_t DIRECTED [NumDirected] = '{
    // A small non-decreasing knot run with a repeated knot at 0 and at 4.
    '{OpWrite, 6'd0, 32'h0000_0000, 6'd0, 32'd0, 1'b0, 31'd0, 1'b0},
    '{OpWrite, 6'd1, 32'h0000_0000, 6'd0, 32'd0, 1'b0, 31'd0, 1'b0},
    '{OpWrite, 6'd2, 32'h0001_0000, 6'd0, 32'd0, 1'b0, 31'd0, 1'b0},
    '{OpWrite, 6'd3, 32'h0002_0000, 6'd0, 32'd0, 1'b0, 31'd0, 1'b0},
    '{OpWrite, 6'd4, 32'h0003_0000, 6'd0, 32'd0, 1'b0, 31'd0, 1'b0},
    '{OpWrite, 6'd5, 32'h0004_0000, 6'd0, 32'd0, 1'b0, 31'd0, 1'b0},
    '{OpWrite, 6'd6, 32'h0004_0000, 6'd0, 32'd0, 1'b0, 31'd0, 1'b0},
    '{OpWrite, 6'd7, 32'h0005_0000, 6'd0, 32'd0, 1'b0, 31'd0, 1'b0},
    '{OpWrite, 6'd8, 32'h0006_0000, 6'd0, 32'd0, 1'b0, 31'd0, 1'b0},
    // Extreme and disordered knots at the top of the table.
    '{OpWrite, 6'd59, 32'h7FFF_FFFF, 6'd0, 32'd0, 1'b0, 31'd0, 1'b0},
    '{OpWrite, 6'd60, 32'h8000_0000, 6'd0, 32'd0, 1'b0, 31'd0, 1'b0},
    '{OpWrite, 6'd61, 32'h1234_5678, 6'd0, 32'd0, 1'b0, 31'd0, 1'b0},
    '{OpWrite, 6'd62, 32'hEDCB_A987, 6'd0, 32'd0, 1'b0, 31'd0, 1'b0},
    '{OpWrite, 6'd63, 32'hFFFF_FFFF, 6'd0, 32'd0, 1'b0, 31'd0, 1'b0},
    // Evaluations inside the run, one on the repeated knot.
    '{OpEval, 6'd0, 32'd0, 6'd0, 32'h0000_8000, 1'b0, 31'd0, 1'b0},
    '{OpEval, 6'd0, 32'd0, 6'd2, 32'h0002_8000, 1'b0, 31'd0, 1'b0},
    '{OpEval, 6'd0, 32'd0, 6'd3, 32'h0004_0000, 1'b0, 31'd0, 1'b0},
    // Parameter below or above every knot of the span gives zero.
    '{OpEval, 6'd0, 32'd0, 6'd0, 32'hFFFF_FFFF, 1'b1, 31'd0, 1'b0},
    '{OpEval, 6'd0, 32'd0, 6'd0, 32'h8000_0000, 1'b1, 31'd0, 1'b0},
    '{OpEval, 6'd0, 32'd0, 6'd4, 32'h7FFF_FFFF, 1'b1, 31'd0, 1'b0},
    // Disordered span, where the saturation of terms and sums matters.
    '{OpEval, 6'd0, 32'd0, 6'd59, 32'h0000_0000, 1'b0, 31'd0, 1'b0},
    // Interval plus order past the table end raises the range error.
    '{OpEval, 6'd0, 32'd0, 6'd60, 32'h0000_0000, 1'b1, 31'd0, 1'b1},
    '{OpEval, 6'd0, 32'd0, 6'd63, 32'h7FFF_FFFF, 1'b1, 31'd0, 1'b1}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [3:0] cfg_data = 4'd0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic operation = OpWrite;
  logic [5:0] knot_index = 6'd0;
  logic signed [31:0] knot_value = 32'sd0;
  logic [5:0] interval = 6'd0;
  logic signed [31:0] param_mu = 32'sd0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [BasisW-1:0] basis_value;
  logic range_error;

  // Predictor state: the knot table as written and the configured order.
  logic signed [31:0] knot_mem [TableDepth];
  logic [3:0] order_reg;

  basis_result_t pending_results [$];
  int fail_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  bspline_basis_eval uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .operation(operation),
    .knot_index(knot_index),
    .knot_value(knot_value),
    .interval(interval),
    .param_mu(param_mu),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .basis_value(basis_value),
    .range_error(range_error)
  );

  always #2 clk = ~clk;

  // The run is cut off if the block hangs anywhere.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // The receiver stalls at random; the rate is set per phase.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Order zero behaves as order one and anything above the cap as the cap.
  function automatic int effective_order();
    int k;
    k = order_reg;
    if (k < 1) k = 1;
    if (k > OrderCap) k = OrderCap;
    return k;
  endfunction

  // One weighted term of the recursion: multiply, divide truncating toward
  // zero, then saturate. A zero denominator drops the term.
  function automatic longint weighted_term(longint num, longint basis, longint den);
    longint q;
    if (den == 0) return 0;
    q = (num * basis) / den;
    if (q < -TermCap) q = -TermCap;
    if (q > TermCap) q = TermCap;
    return q;
  endfunction

  // Cox-de Boor triangle over the stored knots, worked in place in one row.
  function automatic basis_result_t predict_basis(logic [5:0] ivl, logic signed [31:0] mu);
    basis_result_t res;
    longint row [OrderCap + 1];
    longint m, tj, tj1, tjr1, tjr, s;
    int k, p;
    k = effective_order();
    m = mu;
    res.basis = '0;
    res.err = 1'b0;
    if (int'(ivl) + k > TableDepth - 1) begin
      res.err = 1'b1;
      return res;
    end
    for (int j = 0; j < k; j++) begin
      tj = knot_mem[ivl + j];
      tj1 = knot_mem[ivl + j + 1];
      row[j] = (tj <= m && m < tj1) ? QUnit : 0;
    end
    for (int r = 2; r <= k; r++) begin
      for (int j = 0; j + r <= k; j++) begin
        p = ivl + j;
        tj = knot_mem[p];
        tj1 = knot_mem[p + 1];
        tjr1 = knot_mem[p + r - 1];
        tjr = knot_mem[p + r];
        s = weighted_term(m - tj, row[j], tjr1 - tj)
          + weighted_term(tjr - m, row[j + 1], tjr - tj1);
        if (s < 0) s = 0;
        if (s > QUnit) s = QUnit;
        row[j] = s;
      end
    end
    res.basis = row[0][BasisW-1:0];
    return res;
  endfunction

  // Presents one item, holds it through any stall, and on the transfer
  // updates the knot table or queues the expected result. Entered and left
  // at a falling edge; valid stays high so back-to-back items need no gap.
  task automatic send_item(logic op, logic [5:0] kidx, logic [31:0] kval,
                           logic [5:0] ivl, logic [31:0] mu,
                           logic typed, basis_result_t typed_res);
    basis_result_t res;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    knot_index <= kidx;
    knot_value <= kval;
    interval <= ivl;
    param_mu <= mu;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (op == OpWrite) begin
      knot_mem[kidx] = kval;
    end else begin
      res = typed ? typed_res : predict_basis(ivl, mu);
      pending_results.push_back(res);
    end
    @(negedge clk);
  endtask

  // Lets the block drain before the order changes: every result must be in,
  // then the bench idles on so that a trailing knot write can finish.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic write_order(logic [3:0] value);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    order_reg = value;
    @(negedge clk);
  endtask

  // Writes a non-decreasing run of knots, with some repeated knots so that
  // zero denominators come up often.
  task automatic write_sorted_run(int first, int count);
    longint v;
    v = (first > 0) ? longint'(knot_mem[first - 1]) : -longint'($urandom_range(0, 32'h40_0000));
    for (int i = first; i < first + count && i < TableDepth; i++) begin
      if ($urandom_range(0, 4) != 0) v = v + $urandom_range(0, 32'h2_8000);
      if (v > 32'sh7FFF_0000) v = 32'sh7FFF_0000;
      send_item(OpWrite, i[5:0], v[31:0], 6'($urandom), 32'($urandom), 1'b0, '0);
    end
  endtask

  // One random item for the current order. Most evaluations sit inside a
  // valid span with the parameter near its knots; a few run off the table or
  // use a fully random parameter. Writes are mostly ordered, some are noise.
  task automatic send_random_item(int eval_pct);
    int k, ivl, idx;
    longint lo, hi, mu;
    logic [31:0] val;
    k = effective_order();
    if ($urandom_range(0, 99) < eval_pct) begin
      if ($urandom_range(0, 99) < 8) begin
        ivl = $urandom_range(TableDepth - k, TableDepth - 1);
      end else begin
        ivl = $urandom_range(0, TableDepth - 1 - k);
      end
      if (ivl <= TableDepth - 1 - k) begin
        lo = knot_mem[ivl];
        hi = knot_mem[ivl + k];
      end else begin
        lo = 0;
        hi = 0;
      end
      case ($urandom_range(0, 9))
        0: mu = $signed($urandom);
        1: mu = knot_mem[$urandom_range(ivl, (ivl + k < TableDepth) ? ivl + k : ivl)];
        default: begin
          if (hi < lo) hi = lo;
          mu = lo - 32'h8000 + longint'($urandom_range(0, 32'hFFFF_FFFF)) % (hi - lo + 32'h1_0001);
        end
      endcase
      send_item(OpEval, 6'($urandom), 32'($urandom), ivl[5:0], mu[31:0], 1'b0, '0);
    end else if ($urandom_range(0, 99) < 12) begin
      write_sorted_run($urandom_range(0, TableDepth - 1), $urandom_range(2, 12));
    end else begin
      idx = $urandom_range(0, TableDepth - 1);
      if ($urandom_range(0, 1) == 0) begin
        val = $urandom;
      end else begin
        val = (idx > 0) ? knot_mem[idx - 1] + $urandom_range(0, 32'h2_0000) : knot_mem[0];
      end
      send_item(OpWrite, idx[5:0], val, 6'($urandom), 32'($urandom), 1'b0, '0);
    end
  endtask

  // Every transfer on the output side is compared with the oldest
  // expectation, field by field.
  always @(posedge clk) begin
    basis_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: basis_value %0d range_error %0d", basis_value,
               range_error);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (basis_value !== want.basis) begin
          $error("basis_value mismatch: expected %0d actual %0d", want.basis, basis_value);
          fail_count++;
        end
        if (range_error !== want.err) begin
          $error("range_error mismatch: expected %0d actual %0d", want.err, range_error);
          fail_count++;
        end
      end
    end
  end

  initial begin
    // Orders per phase, including both ends of the register and the saturated values.
    int phase_order [NumPhases] = '{4, 1, 2, 8, 3, 0, 15, 5};
    int eval_pct;
    basis_result_t typed_res;
    stim_row_t row;
    order_reg = 4'd4;
    for (int i = 0; i < TableDepth; i++) knot_mem[i] = '0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part at the reset order of four, with no idling.
    for (int i = 0; i < NumDirected; i++) begin
      row = DIRECTED[i];
      typed_res.basis = row.exp_basis;
      typed_res.err = row.exp_err;
      send_item(row.op, row.kidx, row.kval, row.ivl, row.mu, row.typed, typed_res);
    end

    // Random part: the whole table is first rewritten in order, so that no
    // later evaluation reads an unwritten knot.
    for (int p = 0; p < NumPhases; p++) begin
      wait_drained();
      write_order(phase_order[p][3:0]);
      case (p % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 88; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 88; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      if (p == 0) write_sorted_run(0, TableDepth);
      // High orders are slow in the block, so those phases evaluate less.
      eval_pct = (effective_order() >= 7) ? 30 : 50;
      for (int n = 0; n < ItemsPerPhase; n++) send_random_item(eval_pct);
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (64) @(negedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
